[rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: operation codes, beat structs and
// shared constants. No dependencies.
`timescale 1ns / 1ps
package cau_pkg;

  // Operand and result width is fixed by the beat structs below.
  localparam int DW = 16;
  localparam int FracBitsDefault  = 8;
  localparam int FifoDepth = 4;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 is_equal;
    logic                 div_by_zero;
    logic                 overflow;
  } rsp_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    logic                 is_add;
    logic                 is_sub;
    logic                 is_mul;
    logic                 is_div;
    logic                 is_cmp;
    logic                 bzero;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cmd_t;

endpackage

[rtl/cau_front.sv]
// Front end: accepts request beats, decodes the op code, flags a zero divisor
// and writes the classified command into a short queue. Uses cau_pkg.
`timescale 1ns / 1ps
module cau_front
  import cau_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_take,
  output cmd_t cmd
);

  localparam int AW = $clog2(FifoDepth);

  cmd_t mem [FifoDepth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  cmd_t          dec;
  logic          wr_en;
  logic          rd_en;

  // Decode
  always_comb begin
    dec = '0;
    case (req.req_type)
      OP_ADD:  dec.is_add = 1'b1;
      OP_SUB:  dec.is_sub = 1'b1;
      OP_MUL:  dec.is_mul = 1'b1;
      OP_DIV:  dec.is_div = 1'b1;
      OP_CMP:  dec.is_cmp = 1'b1;
      default: dec.is_add = 1'b0;
    endcase
    dec.bzero = (req.b_re == '0) && (req.b_im == '0);
    dec.a_re  = req.a_re;
    dec.a_im  = req.a_im;
    dec.b_re  = req.b_re;
    dec.b_im  = req.b_im;
  end

  assign full      = (count == (AW+1)'(FifoDepth));
  assign cmd_valid = (count != '0);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_valid && cmd_take;
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

[rtl/cau_divider.sv]
// Pipelined restoring divider for unsigned magnitudes, one quotient bit per
// stage, with saturation flag. Uses cau_pkg.
`timescale 1ns / 1ps
module cau_divider
  import cau_pkg::*;
#(
  parameter int NW = 33,  // numerator width
  parameter int DNW = 32, // denominator width
  parameter int QW = 24   // quotient bits kept (already scaled numerator)
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num,
  input  logic [DNW-1:0] den,
  output logic [QW-1:0]  quo,
  output logic           big
);

  // Numerator already carries the fraction shift. Quotient bits above QW only
  // matter as "too big", detected up front by comparing num >> QW to den.
  localparam int RW = DNW + 1;

  logic [RW-1:0]  rem  [QW+1];
  logic [NW-1:0]  nreg [QW+1];
  logic [DNW-1:0] dreg [QW+1];
  logic [QW-1:0]  qreg [QW+1];
  logic           breg [QW+1];

  // Partial remainder starts from the numerator bits above the kept quotient;
  // it is below den whenever the quotient is not too big.
  always_comb begin
    rem[0]  = RW'(num >> QW);
    nreg[0] = num;
    dreg[0] = den;
    qreg[0] = '0;
    breg[0] = ((NW+1)'(num) >> QW) >= (NW+1)'(den);
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW:0] trial;
    logic        nb;
    assign nb    = (QW-1-s < NW) ? nreg[s][QW-1-s] : 1'b0;
    assign trial = {rem[s], nb} - (RW+1)'(dreg[s]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[RW]) begin
          rem[s+1]  <= trial[RW-1:0];
          qreg[s+1] <= qreg[s] | (QW'(1) << (QW-1-s));
        end else begin
          rem[s+1]  <= {rem[s][RW-2:0], nb};
          qreg[s+1] <= qreg[s];
        end
        nreg[s+1] <= nreg[s];
        dreg[s+1] <= dreg[s];
        breg[s+1] <= breg[s];
      end
    end
  end

  assign quo = qreg[QW];
  assign big = breg[QW];

endmodule

[rtl/cau_back.sv]
// Back end: runs add, subtract, multiply, divide and compare in a fixed-depth,
// non-stalling pipeline ending in a result queue. Uses cau_pkg, cau_divider.
`timescale 1ns / 1ps
module cau_back
  import cau_pkg::*;
#(
  parameter int FRAC_BITS  = FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  cmd_t cmd,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  localparam int DATA_WIDTH = DW;
  localparam int PW   = 2*DATA_WIDTH + 1;     // sum of two products
  localparam int NW   = PW + FRAC_BITS;       // scaled numerator
  localparam int DNW  = 2*DATA_WIDTH;         // |b|^2
  localparam int QW   = DATA_WIDTH + 1;       // enough to detect saturation
  localparam int LAT  = QW + 2;               // pipe depth after issue
  localparam int ODEP = LAT + 4;              // result queue depth
  localparam int OAW  = $clog2(ODEP);
  localparam logic [QW-1:0] PMAX = QW'((64'd1 << (DATA_WIDTH-1)) - 1);
  localparam logic [QW-1:0] NMAX = QW'(64'd1 << (DATA_WIDTH-1));

  // Credit: issue only when the result queue has room for all in flight.
  logic [OAW:0] credits;
  logic         issue;
  logic         deliver;
  assign issue    = cmd_valid && (credits != '0);
  assign cmd_take = issue;

  // Saturate sign-magnitude to DATA_WIDTH two's complement.
  function automatic logic [DATA_WIDTH:0] sat(input logic neg, input logic big,
                                              input logic [QW-1:0] mag);
    logic [DATA_WIDTH-1:0] v;
    logic                  o;
    begin
      o = 1'b0;
      v = '0;
      if (!neg) begin
        if (big || mag > PMAX) begin o = 1'b1; v = DATA_WIDTH'(PMAX); end
        else v = DATA_WIDTH'(mag);
      end else begin
        if (big || mag > NMAX) begin o = 1'b1; v = DATA_WIDTH'(NMAX); end
        else v = DATA_WIDTH'(-mag);
      end
      sat = {o, v};
    end
  endfunction

  // Stage 1: four products; the add/sub sums follow in stage 2.
  logic                 v1;
  cmd_t                 c1;
  logic signed [DNW-1:0] p_rr, p_ii, p_ri, p_ir;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= issue;
    c1   <= cmd;
    p_rr <= DNW'(cmd.a_re * cmd.b_re);
    p_ii <= DNW'(cmd.a_im * cmd.b_im);
    p_ri <= DNW'(cmd.a_re * cmd.b_im);
    p_ir <= DNW'(cmd.a_im * cmd.b_re);
  end

  // Stage 2: product sums to sign-magnitude, divisor norm, fast results.
  logic [DNW-1:0]   b2_rr, b2_ii;
  logic             v2;
  cmd_t             c2;
  logic             nr2, ni2;
  logic [PW-1:0]    mr2, mi2;
  logic [DNW-1:0]   den2;
  logic [DATA_WIDTH:0] fr2, fi2;
  logic signed [PW-1:0] sr, si;
  logic signed [DATA_WIDTH:0] er, ei;
  logic [DATA_WIDTH:0] t0, t1;

  always_ff @(posedge clk) begin
    b2_rr <= DNW'(cmd.b_re * cmd.b_re);
    b2_ii <= DNW'(cmd.b_im * cmd.b_im);
  end

  always_comb begin
    sr = '0; si = '0; er = '0; ei = '0;
    if (c1.is_mul) begin
      sr = PW'(p_rr) - PW'(p_ii);
      si = PW'(p_ri) + PW'(p_ir);
    end else begin
      sr = PW'(p_rr) + PW'(p_ii);
      si = PW'(p_ir) - PW'(p_ri);
    end
    if (c1.is_sub) begin
      er = (DATA_WIDTH+1)'(c1.a_re) - (DATA_WIDTH+1)'(c1.b_re);
      ei = (DATA_WIDTH+1)'(c1.a_im) - (DATA_WIDTH+1)'(c1.b_im);
    end else begin
      er = (DATA_WIDTH+1)'(c1.a_re) + (DATA_WIDTH+1)'(c1.b_re);
      ei = (DATA_WIDTH+1)'(c1.a_im) + (DATA_WIDTH+1)'(c1.b_im);
    end
    t0 = sat(er[DATA_WIDTH], 1'b0,
             QW'(er[DATA_WIDTH] ? -er : er));
    t1 = sat(ei[DATA_WIDTH], 1'b0,
             QW'(ei[DATA_WIDTH] ? -ei : ei));
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    c2   <= c1;
    nr2  <= sr[PW-1];
    ni2  <= si[PW-1];
    mr2  <= sr[PW-1] ? PW'(-sr) : PW'(sr);
    mi2  <= si[PW-1] ? PW'(-si) : PW'(si);
    den2 <= b2_rr + b2_ii;
    fr2  <= t0;
    fi2  <= t1;
  end

  // Divider lanes plus a matched delay line for everything else.
  logic [QW-1:0] qr, qi;
  logic          bgr, bgi;
  cau_divider #(.NW(NW), .DNW(DNW), .QW(QW)) u_div_re (
    .clk(clk), .en(1'b1), .num(NW'(mr2) << FRAC_BITS),
    .den(den2 == '0 ? DNW'(1) : den2), .quo(qr), .big(bgr)
  );
  cau_divider #(.NW(NW), .DNW(DNW), .QW(QW)) u_div_im (
    .clk(clk), .en(1'b1), .num(NW'(mi2) << FRAC_BITS),
    .den(den2 == '0 ? DNW'(1) : den2), .quo(qi), .big(bgi)
  );

  typedef struct packed {
    logic                v;
    cmd_t                c;
    logic                nr;
    logic                ni;
    logic [PW-1:0]       mr;
    logic [PW-1:0]       mi;
    logic [DATA_WIDTH:0] fr;
    logic [DATA_WIDTH:0] fi;
  } dly_t;

  dly_t dly [QW+1];
  assign dly[0] = '{v: v2, c: c2, nr: nr2, ni: ni2, mr: mr2, mi: mi2,
                    fr: fr2, fi: fi2};
  for (genvar k = 0; k < QW; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) dly[k+1].v <= 1'b0;
      else     dly[k+1].v <= dly[k].v;
      dly[k+1].c  <= dly[k].c;
      dly[k+1].nr <= dly[k].nr;
      dly[k+1].ni <= dly[k].ni;
      dly[k+1].mr <= dly[k].mr;
      dly[k+1].mi <= dly[k].mi;
      dly[k+1].fr <= dly[k].fr;
      dly[k+1].fi <= dly[k].fi;
    end
  end

  // Final select.
  dly_t                e;
  rsp_t                r;
  logic [DATA_WIDTH:0] s0, s1;
  assign e = dly[QW];
  always_comb begin
    r  = '0;
    s0 = '0;
    s1 = '0;
    if (e.c.is_add || e.c.is_sub) begin
      s0 = e.fr;
      s1 = e.fi;
    end else if (e.c.is_mul) begin
      s0 = sat(e.nr, (e.mr >> FRAC_BITS) > PW'(NMAX),
               QW'(e.mr >> FRAC_BITS));
      s1 = sat(e.ni, (e.mi >> FRAC_BITS) > PW'(NMAX),
               QW'(e.mi >> FRAC_BITS));
    end else if (e.c.is_div && !e.c.bzero) begin
      s0 = sat(e.nr, bgr, qr);
      s1 = sat(e.ni, bgi, qi);
    end
    r.res_re      = s0[DATA_WIDTH-1:0];
    r.res_im      = s1[DATA_WIDTH-1:0];
    r.overflow    = s0[DATA_WIDTH] | s1[DATA_WIDTH];
    r.div_by_zero = e.c.is_div && e.c.bzero;
    r.is_equal    = e.c.is_cmp && (e.c.a_re == e.c.b_re) && (e.c.a_im == e.c.b_im);
  end

  // Result queue.
  rsp_t         oq [ODEP];
  logic [OAW-1:0] owr, ord;
  logic [OAW:0]   ocnt;
  assign empty   = (ocnt == '0);
  assign deliver = pop && !empty;
  assign rsp     = oq[ord];

  always_ff @(posedge clk) begin
    if (e.v) oq[owr] <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr     <= '0;
      ord     <= '0;
      ocnt    <= '0;
      credits <= (OAW+1)'(ODEP);
    end else begin
      if (e.v)     owr <= (owr == OAW'(ODEP-1)) ? '0 : owr + 1'b1;
      if (deliver) ord <= (ord == OAW'(ODEP-1)) ? '0 : ord + 1'b1;
      ocnt    <= ocnt + (OAW+1)'(e.v) - (OAW+1)'(deliver);
      credits <= credits - (OAW+1)'(issue) + (OAW+1)'(deliver);
    end
  end

endmodule

[rtl/complex_arith_unit.sv]
// Top level of the complex arithmetic unit: front decoder/queue and back
// arithmetic pipeline. Uses cau_pkg, cau_front, cau_back.
`timescale 1ns / 1ps
// Takes one request beat per cycle while full is low and returns one result
// beat for each, in order. An accepted request passes the request queue, the
// product and sum stages and the bit-per-stage divider pipeline that all
// operations pass through, then the result queue; throughput is one beat per
// cycle while pop keeps up. Results queue internally so input stalls only when
// that queue plus the pipeline is full. No state survives an item.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS  = FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  cau_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd(cmd), .empty(empty), .pop(pop), .rsp(rsp)
  );

endmodule

[rtl/cau_checker.sv]
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Uses cau_pkg.
`timescale 1ns / 1ps
module cau_port_checks
  import cau_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input rsp_t rsp
);

  // Only divide can flag a zero divisor, which forces zero parts.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.div_by_zero) |-> (rsp.res_re == '0 && rsp.res_im == '0 &&
                                     !rsp.overflow))
    else $error("div_by_zero with nonzero result");

  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.is_equal) |-> (!rsp.div_by_zero && !rsp.overflow))
    else $error("compare beat carries other flags");

  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queues not cleared after reset");

  a_head_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(rsp))
    else $error("waiting result changed");

endmodule

bind complex_arith_unit cau_port_checks u_cau_port_checks (
  .clk(clk), .rst(rst), .full(full),
  .empty(empty), .pop(pop), .rsp(rsp)
);
